// File: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types and constants shared by the sorted list table and its cells.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;

    typedef logic [KEY_BITS-1:0] slt_key_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_DEL_VAL = 3'd1,
        FN_DEL_POS = 3'd2,
        FN_READ    = 3'd3,
        FN_FIND    = 3'd4
    } slt_func_t;

    typedef enum logic [1:0] {
        MOVE_HOLD,
        MOVE_LOAD,
        MOVE_LEFT,
        MOVE_RIGHT
    } slt_move_t;

    typedef struct packed {
        logic      cmp_en;
        slt_move_t move;
    } slt_cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } slt_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [31:0]       key;
        logic [POS_W-1:0]  position;
    } slt_req_t;

    typedef struct packed {
        logic             ok;
        logic [31:0]      read_key;
        logic [POS_W-1:0] found_position;
        logic [CNT_W-1:0] count;
    } slt_rsp_t;

endpackage

// File: rtl/core/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted row: holds a key, compares it against the broadcast
// key and takes its next key from itself, the bus or either neighbor.
// ----------------------------------------------------------------------------
module slt_cell
    import slt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  slt_cell_cmd_t cmd,
    input  logic          occupied,
    input  slt_key_t      key,
    input  slt_key_t      left_entry,
    input  slt_key_t      right_entry,
    output slt_key_t      entry,
    output logic          gt,
    output logic          eq
);

    slt_key_t entry_reg;
    slt_key_t entry_next;
    logic     gt_reg;
    logic     gt_next;
    logic     eq_reg;
    logic     eq_next;

    always_comb
    begin
        case (cmd.move)
            MOVE_HOLD:  entry_next = entry_reg;
            MOVE_LOAD:  entry_next = key;
            MOVE_LEFT:  entry_next = left_entry;
            MOVE_RIGHT: entry_next = right_entry;
            default:    entry_next = entry_reg;
        endcase
    end

    always_comb
    begin
        gt_next = gt_reg;
        eq_next = eq_reg;
        if (cmd.cmp_en)
        begin
            gt_next = occupied && (key > entry_reg);
            eq_next = occupied && (key == entry_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            gt_reg <= gt_next;
            eq_reg <= eq_next;
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

// File: rtl/core/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table
// Ascending key table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// response: the request waits in the execute state until its result commits
//   into the response register; a stalled waiting response holds that commit
// one request at a time: the next is not accepted until the previous commits;
//   the cell row compares in the accept cycle and shifts in the commit cycle
// a waiting response does not block the next request transfer
// reset: count and control clear at once, stored keys stay undefined
module sorted_list_table
    import slt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  slt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output slt_rsp_t rsp
);

    slt_state_t       state_reg;
    slt_state_t       state_next;
    slt_req_t         op_reg;
    slt_req_t         op_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    slt_rsp_t         rsp_reg;
    slt_rsp_t         rsp_next;

    slt_cell_cmd_t    cmd   [CAPACITY];
    slt_key_t         entry [CAPACITY];
    logic [CAPACITY-1:0] gt_vec;
    logic [CAPACITY-1:0] eq_vec;
    slt_key_t         bcast_key;

    logic             req_xfer;
    logic             commit;
    logic [CNT_W-1:0] idx;
    logic             hit;
    logic             pos_ok;
    logic [POS_W-1:0] pos_m1;
    logic [CNT_W-1:0] del_at;
    logic             do_ins;
    logic             do_del;
    logic             res_ok;
    slt_key_t         res_key;

    assign req_xfer  = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign commit    = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign bcast_key = (state_reg == ST_IDLE) ? slt_key_t'(req.key) : slt_key_t'(op_reg.key);

    // cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        slt_key_t left_entry;
        slt_key_t right_entry;
        if (g == 0)
        begin : g_first
            assign left_entry = entry[g];
        end
        else
        begin : g_mid_l
            assign left_entry = entry[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_entry = entry[g];
        end
        else
        begin : g_mid_r
            assign right_entry = entry[g+1];
        end

        slt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd[g]),
            .occupied    (CNT_W'(g) < count_reg),
            .key         (bcast_key),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry[g]),
            .gt          (gt_vec[g]),
            .eq          (eq_vec[g])
        );
    end

    // smaller keys form a prefix, so their number is the lower bound
    assign idx    = CNT_W'($countones(gt_vec));
    assign hit    = (idx < CNT_W'(CAPACITY)) && eq_vec[idx[IDX_W-1:0]];
    assign pos_ok = (op_reg.position != '0) && (CNT_W'(op_reg.position) <= count_reg);
    assign pos_m1 = op_reg.position - POS_W'(1);

    always_comb
    begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        del_at  = idx;
        res_ok  = 1'b0;
        res_key = '0;
        rsp_next.found_position = '0;
        case (op_reg.func)
            FN_INSERT:
            begin
                res_ok = (count_reg < CNT_W'(CAPACITY));
                do_ins = res_ok;
            end
            FN_DEL_VAL:
            begin
                res_ok = hit;
                do_del = hit;
            end
            FN_DEL_POS:
            begin
                res_ok = pos_ok;
                do_del = pos_ok;
                del_at = CNT_W'(pos_m1);
            end
            FN_READ:
            begin
                res_ok = pos_ok;
                if (pos_ok)
                begin
                    res_key = entry[pos_m1[IDX_W-1:0]];
                end
            end
            FN_FIND:
            begin
                res_ok = hit;
                rsp_next.found_position = POS_W'(idx + CNT_W'(1));
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase

        count_next = count_reg;
        if (commit && do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (commit && do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_next.ok       = res_ok;
        rsp_next.read_key = 32'(res_key);
        rsp_next.count    = count_next;
    end

    // per-cell move commands
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cmd[i].cmp_en = req_xfer;
            cmd[i].move   = MOVE_HOLD;
            if (commit && do_ins)
            begin
                if (CNT_W'(i) == idx)
                begin
                    cmd[i].move = MOVE_LOAD;
                end
                else if (CNT_W'(i) > idx)
                begin
                    cmd[i].move = MOVE_LEFT;
                end
            end
            else if (commit && do_del)
            begin
                if ((CNT_W'(i) >= del_at) && (i < CAPACITY - 1))
                begin
                    cmd[i].move = MOVE_RIGHT;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rsp_valid_next = rsp_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next    = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // assertions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> state_reg == ST_EXEC)
        else $error("request transfer did not start execution");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("count changed without a commit");

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> ((gt_vec & (gt_vec + CAPACITY'(1))) == '0))
        else $error("smaller-key flags are not a prefix, row out of order");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit && do_ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

endmodule

// File: test/slt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slt_checker
// Watches both channels of the sorted list table and keeps its own copy of the
// ordered key table. Each request transfer is applied to that copy to form the
// expected response. Each response transfer is compared field by field with
// the oldest expected one.
// ----------------------------------------------------------------------------
module slt_checker
    import slt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  slt_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  slt_rsp_t rsp,
    output int       fail_count,
    output int       outstanding,
    output int       checked,
    output int       full_hits
);

    slt_key_t    tbl [CAPACITY];
    int unsigned fill;
    slt_rsp_t    expected_rsp_q [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        checked     = 0;
        full_hits   = 0;
        fill        = 0;
    end

    // index of the first stored key not smaller than k
    function automatic int unsigned first_not_below(slt_key_t k);
        int unsigned i;
        i = 0;
        while (i < fill && k > tbl[i])
            i++;
        return i;
    endfunction

    function automatic void drop_entry(int unsigned idx);
        int unsigned i;
        for (i = idx; i + 1 < fill; i++)
            tbl[i] = tbl[i + 1];
        fill--;
    endfunction

    function automatic slt_rsp_t apply_op(slt_req_t r);
        slt_rsp_t    o;
        int unsigned idx;
        int unsigned i;
        o = '0;
        case (r.func)
            FN_INSERT:
            begin
                if (fill < CAPACITY)
                begin
                    idx = first_not_below(r.key);
                    for (i = fill; i > idx; i--)
                        tbl[i] = tbl[i - 1];
                    tbl[idx] = r.key;
                    fill++;
                    o.ok = 1'b1;
                end
                else
                    full_hits++;
            end
            FN_DEL_VAL:
            begin
                idx = first_not_below(r.key);
                if (idx < fill && tbl[idx] == r.key)
                begin
                    drop_entry(idx);
                    o.ok = 1'b1;
                end
            end
            FN_DEL_POS:
            begin
                if (r.position >= 1 && r.position <= fill)
                begin
                    drop_entry(r.position - 1);
                    o.ok = 1'b1;
                end
            end
            FN_READ:
            begin
                if (r.position >= 1 && r.position <= fill)
                begin
                    o.read_key = tbl[r.position - 1];
                    o.ok       = 1'b1;
                end
            end
            FN_FIND:
            begin
                idx              = first_not_below(r.key);
                o.found_position = POS_W'(idx + 1);
                o.ok             = (idx < fill && tbl[idx] == r.key);
            end
            default:
            begin
            end
        endcase
        o.count = CNT_W'(fill);
        return o;
    endfunction

    task automatic note_failure(string detail);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, detail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slt_rsp_t exp_rsp;
        if (!rst_n)
        begin
            fill = 0;
            expected_rsp_q.delete();
        end
        else
        begin
            // a response never belongs to the request taken at the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    note_failure($sformatf(
                        "response with none pending: ok=%0b key=%h pos=%0d count=%0d",
                        rsp.ok, rsp.read_key, rsp.found_position, rsp.count));
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    checked++;
                    if (rsp.ok !== exp_rsp.ok || rsp.read_key !== exp_rsp.read_key ||
                        rsp.found_position !== exp_rsp.found_position ||
                        rsp.count !== exp_rsp.count)
                        note_failure({
                            $sformatf("response %0d: expected ok=%0b key=%h pos=%0d count=%0d",
                                      checked, exp_rsp.ok, exp_rsp.read_key,
                                      exp_rsp.found_position, exp_rsp.count),
                            $sformatf(", got ok=%0b key=%h pos=%0d count=%0d",
                                      rsp.ok, rsp.read_key, rsp.found_position,
                                      rsp.count)});
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(apply_op(req));
        end
        outstanding = expected_rsp_q.size();
    end

endmodule

// File: test/tb_sorted_list_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_table
// Drives the sorted list table with a short directed sequence and then phases
// of random operations that fill, drain and churn the table. Sender bursts,
// receiver stalls and a long receiver hold vary the timing. The checker
// beside the block checks every response.
// ----------------------------------------------------------------------------
module tb_sorted_list_table;
    import slt_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int LONG_HOLD    = 60;
    localparam int PHASES       = 25;
    localparam int PHASE_ITEMS  = 50;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    slt_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    slt_rsp_t rsp;

    int       fail_count;
    int       outstanding;
    int       checked;
    int       full_hits;

    int       sent;
    int       burst_left;
    int       idle_cycles;
    int       hold_requests;
    bit       steady;
    slt_key_t key_pool [8];

    sorted_list_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    slt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked),
        .full_hits   (full_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // give up when neither channel has a transfer for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: stall pattern switches between random modes; long hold on request
    initial
    begin : rsp_side
        int holds_done;
        int mode;
        int span;
        int c;
        holds_done = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            if (hold_requests != holds_done)
            begin
                holds_done++;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(5, 40);
                for (c = 0; c < span && hold_requests == holds_done; c++)
                begin
                    case (mode)
                        0:       rsp_stall <= 1'b0;
                        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                        2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                        default: rsp_stall <= c[1];
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    // one request transfer, then maybe a gap before the next burst
    task automatic issue(input logic [FUNC_W-1:0] f, input slt_key_t k,
                         input logic [POS_W-1:0] p);
        slt_req_t r;
        r.func     = f;
        r.key      = k;
        r.position = p;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        sent++;
        if (!steady)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 10);
            end
        end
    endtask

    task automatic drain_pause();
        req_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    function automatic slt_key_t pick_key();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return key_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 4) == 0)
            return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, CAPACITY + 1));
    endfunction

    initial
    begin
        int               ph;
        int               n;
        int               j;
        int               roll;
        int               ins_pct;
        int               del_pct;
        logic [FUNC_W-1:0] f;

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        sent          = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        hold_requests = 0;
        steady        = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table corners
        issue(FN_READ,    '0, 0);
        issue(FN_READ,    '0, 1);
        issue(FN_FIND,    32'h0000_1234, 0);
        issue(FN_DEL_VAL, '0, 0);
        issue(FN_DEL_POS, '0, 1);
        // extremes and duplicates
        issue(FN_INSERT,  '1, 0);
        issue(FN_INSERT,  '0, 31);
        issue(FN_INSERT,  32'h8000_0000, 0);
        issue(FN_INSERT,  32'h8000_0000, 0);
        issue(FN_FIND,    32'h8000_0000, 0);
        issue(FN_FIND,    32'h7FFF_FFFF, 0);
        issue(FN_READ,    '0, 4);
        issue(FN_READ,    '0, 5);
        issue(FN_READ,    '1, 31);
        issue(FN_DEL_POS, '0, 0);
        issue(FN_DEL_POS, '0, 5);
        issue(FN_DEL_VAL, 32'h0000_0001, 0);
        issue(FN_DEL_VAL, '1, 0);
        // absent key above every stored key lands at count+1
        issue(FN_FIND,    '1, 0);
        issue(3'd5,       32'h5555_5555, 1);
        issue(3'd6,       '0, 0);
        issue(3'd7,       '1, 31);
        issue(FN_DEL_POS, '0, 1);
        issue(FN_READ,    '0, 1);
        drain_pause();

        for (ph = 0; ph < PHASES; ph++)
        begin
            for (j = 0; j < 8; j++)
                key_pool[j] = (j < 2) ? $urandom_range(0, 20) : $urandom;
            case (ph % 3)
                0:
                begin
                    ins_pct = 65;
                    del_pct = 10;
                end
                1:
                begin
                    ins_pct = 10;
                    del_pct = 60;
                end
                default:
                begin
                    ins_pct = 35;
                    del_pct = 30;
                end
            endcase
            // long receiver hold while requests keep coming back to back
            steady = (ph == 3 || ph == 12);
            if (steady)
                hold_requests++;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    f = FUNC_W'($urandom_range(5, 7));
                else if (roll < ins_pct)
                    f = FN_INSERT;
                else if (roll < ins_pct + del_pct)
                    f = ($urandom_range(0, 1) != 0) ? FN_DEL_VAL : FN_DEL_POS;
                else
                    f = ($urandom_range(0, 1) != 0) ? FN_READ : FN_FIND;
                issue(f, pick_key(), pick_position());
            end
            steady = 1'b0;
            if (ph == 0 || ph == 7 || $urandom_range(0, 4) == 0)
                drain_pause();
        end

        req_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        $display("run covered %0d request transfers over all operations and unused codes",
                 sent);
        $display("%0d responses checked, %0d inserts refused on a full table",
                 checked, full_hits);
        if (fail_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
